// ===== hw/rtl/gpe_pkg.sv =====
// shared types, constants and tables of the glide path integrator
`timescale 1ns / 1ps
`default_nettype none

package gpe_pkg;

   // cordic step count (12 to 32)
   localparam int CORDIC_ITERATIONS = 24;
   localparam int ITER_W = 6;

   // fixed point limits and angles in q2.30
   localparam logic [47:0] MAXM = 48'h7FFF_FFFF_FFFF;
   localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
   localparam logic signed [34:0] HALFPI_Q30 = 35'sd1686629713;
   localparam logic signed [34:0] TWOPI_Q30 = 35'sd6746518852;
   localparam logic [32:0] TWOPI_U = 33'd6746518852;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [47:0] HALF_Q16 = 48'sd32768;

   // register indexes
   localparam logic [2:0] REG_TIME_STEP = 3'd0;
   localparam logic [2:0] REG_END_TIME = 3'd1;
   localparam logic [2:0] REG_MASS = 3'd2;
   localparam logic [2:0] REG_GRAVITY = 3'd3;
   localparam logic [2:0] REG_AIR_DENSITY = 3'd4;
   localparam logic [2:0] REG_WING_AREA = 3'd5;
   localparam logic [2:0] REG_LIFT_COEF = 3'd6;
   localparam logic [2:0] REG_DRAG_COEF = 3'd7;

   // input item
   typedef struct packed {
      logic               action;
      logic signed [31:0] initial_speed;
      logic signed [31:0] initial_angle;
      logic signed [47:0] initial_position;
      logic signed [47:0] initial_height;
   } req_type;

   // result item
   typedef struct packed {
      logic [31:0]        time_now;
      logic signed [31:0] speed_now;
      logic signed [31:0] angle_now;
      logic signed [47:0] position_now;
      logic signed [47:0] height_now;
      logic               stopped;
      logic               overflow;
   } rsp_type;

   // request to a shared arithmetic unit
   typedef struct packed {
      logic               start;
      logic signed [47:0] a;
      logic signed [47:0] b;
   } unit_req_type;

   // answer of a shared arithmetic unit
   typedef struct packed {
      logic               done;
      logic               ovf;
      logic signed [47:0] value;
   } unit_rsp_type;

   // magnitude of a signed 48-bit value
   function automatic logic [47:0] mag48(input logic signed [47:0] v);
      mag48 = v[47] ? 48'(-v) : 48'(v);
   endfunction

   // arctangent of 2^-i in q2.30
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0: r = 32'd843314856;
         5'd1: r = 32'd497837829;
         5'd2: r = 32'd263043836;
         5'd3: r = 32'd133525158;
         5'd4: r = 32'd67021687;
         5'd5: r = 32'd33543515;
         5'd6: r = 32'd16775850;
         5'd7: r = 32'd8388437;
         5'd8: r = 32'd4194282;
         5'd9: r = 32'd2097149;
         5'd10: r = 32'd1048575;
         5'd11: r = 32'd524287;
         5'd12: r = 32'd262143;
         5'd13: r = 32'd131071;
         5'd14: r = 32'd65535;
         5'd15: r = 32'd32767;
         5'd16: r = 32'd16383;
         5'd17: r = 32'd8191;
         5'd18: r = 32'd4095;
         5'd19: r = 32'd2047;
         5'd20: r = 32'd1023;
         5'd21: r = 32'd511;
         5'd22: r = 32'd255;
         5'd23: r = 32'd127;
         5'd24: r = 32'd63;
         5'd25: r = 32'd31;
         5'd26: r = 32'd15;
         5'd27: r = 32'd7;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         default: r = 32'd0;
      endcase
      atan_q30 = r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gpe_mul.sv =====
// multi-cycle saturating fixed point multiplier on one 32x32 multiplier
`timescale 1ns / 1ps
`default_nettype none

module gpe_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gpe_pkg::unit_req_type req,
   output gpe_pkg::unit_rsp_type      rsp
);

   localparam logic [2:0] MP_IDLE = 3'd0;
   localparam logic [2:0] MP_LOW = 3'd1;
   localparam logic [2:0] MP_MID1 = 3'd2;
   localparam logic [2:0] MP_MID2 = 3'd3;
   localparam logic [2:0] MP_FIN = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [47:0] ua_ff, ua_in, ub_ff, ub_in;
   logic        neg_ff, neg_in;
   logic [63:0] pl_ff, pl_in;
   logic [47:0] pm1_ff, pm1_in, pm2_ff, pm2_in;
   logic [31:0] mop_a, mop_b;
   logic [63:0] prod;
   logic [48:0] mid;
   logic [48:0] sum;
   logic        sat;
   logic [47:0] rmag;

   // operand select for the shared multiplier
   always_comb begin
      case (phase_ff)
         MP_MID1: begin
            mop_a = 32'(ua_ff[47:32]);
            mop_b = ub_ff[31:0];
         end
         MP_MID2: begin
            mop_a = ua_ff[31:0];
            mop_b = 32'(ub_ff[47:32]);
         end
         default: begin
            mop_a = ua_ff[31:0];
            mop_b = ub_ff[31:0];
         end
      endcase
   end

   assign prod = mop_a * mop_b;

   // combine partial products and saturate
   always_comb begin
      mid = {1'b0, pm1_ff} + {1'b0, pm2_ff};
      sum = 49'({mid[30:0], 16'h0000}) + 49'(pl_ff[63:16]);
      sat = ((|ua_ff[47:32]) && (|ub_ff[47:32])) || (|mid[48:31]) ||
            (sum > 49'(gpe_pkg::MAXM));
      rmag = sat ? gpe_pkg::MAXM : sum[47:0];
      rsp.done = (phase_ff == MP_FIN);
      rsp.ovf = sat;
      rsp.value = neg_ff ? -$signed(rmag) : $signed(rmag);
   end

   // sequencing
   always_comb begin
      phase_in = phase_ff;
      ua_in = ua_ff;
      ub_in = ub_ff;
      neg_in = neg_ff;
      pl_in = pl_ff;
      pm1_in = pm1_ff;
      pm2_in = pm2_ff;
      unique case (phase_ff)
         MP_IDLE: begin
            if (req.start) begin
               ua_in = gpe_pkg::mag48(req.a);
               ub_in = gpe_pkg::mag48(req.b);
               neg_in = req.a[47] ^ req.b[47];
               phase_in = MP_LOW;
            end
         end
         MP_LOW: begin
            pl_in = prod;
            phase_in = MP_MID1;
         end
         MP_MID1: begin
            pm1_in = prod[47:0];
            phase_in = MP_MID2;
         end
         MP_MID2: begin
            pm2_in = prod[47:0];
            phase_in = MP_FIN;
         end
         MP_FIN: phase_in = MP_IDLE;
         default: phase_in = MP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MP_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      ua_ff <= ua_in;
      ub_ff <= ub_in;
      neg_ff <= neg_in;
      pl_ff <= pl_in;
      pm1_ff <= pm1_in;
      pm2_ff <= pm2_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/gpe_div.sv =====
// bit-serial saturating fixed point divider
`timescale 1ns / 1ps
`default_nettype none

module gpe_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gpe_pkg::unit_req_type req,
   output gpe_pkg::unit_rsp_type      rsp
);

   localparam logic [1:0] DP_IDLE = 2'd0;
   localparam logic [1:0] DP_RUN = 2'd1;
   localparam logic [1:0] DP_FIN = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [63:0] num_ff, num_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] ud_ff, ud_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        zero_ff, zero_in;
   logic        nneg_ff, nneg_in;
   logic        dneg_ff, dneg_in;
   logic [47:0] un;
   logic [48:0] shifted, diff;
   logic        ge, sat, neg;
   logic [47:0] qmag;

   // one quotient bit per cycle
   always_comb begin
      un = gpe_pkg::mag48(req.a);
      shifted = {rem_ff, num_ff[63]};
      diff = shifted - {1'b0, ud_ff};
      ge = (shifted >= {1'b0, ud_ff});
   end

   // result and saturation
   always_comb begin
      sat = zero_ff || (|num_ff[63:47]);
      qmag = sat ? gpe_pkg::MAXM : num_ff[47:0];
      neg = zero_ff ? nneg_ff : (nneg_ff ^ dneg_ff);
      rsp.done = (phase_ff == DP_FIN);
      rsp.ovf = sat;
      rsp.value = neg ? -$signed(qmag) : $signed(qmag);
   end

   // sequencing
   always_comb begin
      phase_in = phase_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      ud_in = ud_ff;
      cnt_in = cnt_ff;
      zero_in = zero_ff;
      nneg_in = nneg_ff;
      dneg_in = dneg_ff;
      unique case (phase_ff)
         DP_IDLE: begin
            if (req.start) begin
               num_in = {un, 16'h0000};
               rem_in = '0;
               ud_in = gpe_pkg::mag48(req.b);
               cnt_in = '0;
               zero_in = (req.b == '0);
               nneg_in = req.a[47];
               dneg_in = req.b[47];
               phase_in = (req.b == '0) ? DP_FIN : DP_RUN;
            end
         end
         DP_RUN: begin
            rem_in = ge ? diff[47:0] : shifted[47:0];
            num_in = {num_ff[62:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               phase_in = DP_FIN;
            end
         end
         DP_FIN: phase_in = DP_IDLE;
         default: phase_in = DP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= DP_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      ud_ff <= ud_in;
      cnt_ff <= cnt_in;
      zero_ff <= zero_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/glide_path_euler_step.sv =====
// glide path euler integrator: sequencer, cordic, state and channels
// a load item, or a step once stopped, goes from the idle state to the done state and
// is written to the output register once it is free. an advancing step runs 14 angle
// reduction steps, 2 fold steps, 24 cordic iterations, 16 multiplies on the shared multiplier
// and 2 divides on the bit-serial divider; one item is in work at a time.
// synchronous active-high reset clears control, state and configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module glide_path_euler_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire gpe_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output gpe_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_data
);

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_REDUCE = 4'd1;
   localparam logic [3:0] ST_FOLD = 4'd2;
   localparam logic [3:0] ST_FLIP = 4'd3;
   localparam logic [3:0] ST_CORDIC = 4'd4;
   localparam logic [3:0] ST_ISSUE = 4'd5;
   localparam logic [3:0] ST_WAIT = 4'd6;
   localparam logic [3:0] ST_UPDATE = 4'd7;
   localparam logic [3:0] ST_DONE = 4'd8;

   // arithmetic program
   localparam logic [4:0] OP_BASE_RHO = 5'd0;
   localparam logic [4:0] OP_BASE_V1 = 5'd1;
   localparam logic [4:0] OP_BASE_V2 = 5'd2;
   localparam logic [4:0] OP_BASE_S = 5'd3;
   localparam logic [4:0] OP_LIFT = 5'd4;
   localparam logic [4:0] OP_DRAG = 5'd5;
   localparam logic [4:0] OP_WEIGHT = 5'd6;
   localparam logic [4:0] OP_W_SIN = 5'd7;
   localparam logic [4:0] OP_W_COS = 5'd8;
   localparam logic [4:0] OP_MV = 5'd9;
   localparam logic [4:0] OP_DX = 5'd10;
   localparam logic [4:0] OP_DH = 5'd11;
   localparam logic [4:0] OP_DIV_V = 5'd12;
   localparam logic [4:0] OP_DIV_G = 5'd13;
   localparam logic [4:0] OP_DV_DT = 5'd14;
   localparam logic [4:0] OP_DG_DT = 5'd15;
   localparam logic [4:0] OP_DX_DT = 5'd16;
   localparam logic [4:0] OP_DH_DT = 5'd17;

   localparam logic signed [48:0] MAX32 = 49'sd2147483647;
   localparam logic signed [48:0] MIN32 = -49'sd2147483648;
   localparam logic signed [48:0] MAXM49 = 49'sd140737488355327;

   localparam logic [5:0] ITER_LAST = 6'(gpe_pkg::CORDIC_ITERATIONS - 1);

   // configuration registers
   logic [31:0]        time_step_ff, end_time_ff, mass_ff, gravity_ff;
   logic [31:0]        rho_ff, area_ff;
   logic signed [31:0] cl_ff;
   logic [30:0]        cd_ff;

   // control and state
   logic [3:0]         state_ff, state_in;
   logic signed [31:0] speed_ff, speed_in, angle_ff, angle_in;
   logic signed [47:0] pos_ff, pos_in, height_ff, height_in;
   logic [31:0]        time_ff, time_in;
   logic               stop_ff, stop_in, ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gpe_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // working registers
   logic [45:0]        rmag_ff, rmag_in;
   logic               zneg_ff, zneg_in;
   logic [3:0]         k_ff, k_in;
   logic signed [34:0] z_ff, z_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic               flip_ff, flip_in;
   logic [5:0]         iter_ff, iter_in;
   logic [4:0]         op_ff, op_in;
   logic signed [47:0] base_ff, base_in, lift_ff, lift_in, drag_ff, drag_in;
   logic signed [47:0] w_ff, w_in, t1_ff, t1_in, t2_ff, t2_in, mv_ff, mv_in;
   logic signed [47:0] dx_ff, dx_in, dh_ff, dh_in, dv_ff, dv_in, dg_ff, dg_in;

   // shared units
   gpe_pkg::unit_req_type mul_req, div_req;
   gpe_pkg::unit_rsp_type mul_rsp, div_rsp;

   gpe_mul u_mul (
      .clock(clock),
      .reset(reset),
      .req  (mul_req),
      .rsp  (mul_rsp)
   );

   gpe_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   // helpers
   logic signed [45:0] ang46;
   logic [46:0]        twopi_k;
   logic [34:0]        zm;
   logic signed [34:0] zs;
   logic signed [33:0] xs, ys, xf;
   logic signed [34:0] atan_z;
   logic signed [47:0] sn_w, cs_w;
   logic signed [47:0] op_a, op_b;
   logic signed [48:0] nsum;
   logic signed [47:0] nclip;
   logic               nsat;
   logic               is_div;
   logic               unit_done, unit_ovf;
   logic signed [47:0] unit_value;
   logic signed [48:0] sp_sum, an_sum, po_sum, he_sum;
   logic [32:0]        t_sum;
   logic               load_stop, step_stop;
   logic               accept, rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // angle scaling, cordic shifts and sine/cosine taps
   always_comb begin
      ang46 = {angle_ff, 14'h0000};
      twopi_k = {14'h0000, gpe_pkg::TWOPI_U} << k_ff;
      zm = {2'b00, rmag_ff[32:0]};
      zs = zneg_ff ? -$signed(zm) : $signed(zm);
      xs = x_ff >>> iter_ff[4:0];
      ys = y_ff >>> iter_ff[4:0];
      atan_z = $signed({3'b000, gpe_pkg::atan_q30(iter_ff[4:0])});
      xf = flip_ff ? -x_ff : x_ff;
      sn_w = 48'(y_ff >>> 14);
      cs_w = 48'(xf >>> 14);
   end

   // operand select per program step
   always_comb begin
      op_a = '0;
      op_b = '0;
      is_div = 1'b0;
      nsum = '0;
      case (op_ff) inside
         OP_BASE_RHO: begin op_a = gpe_pkg::HALF_Q16; op_b = 48'(rho_ff); end
         OP_BASE_V1, OP_BASE_V2: begin op_a = base_ff; op_b = 48'(speed_ff); end
         OP_BASE_S: begin op_a = base_ff; op_b = 48'(area_ff); end
         OP_LIFT: begin op_a = 48'(cl_ff); op_b = base_ff; end
         OP_DRAG: begin op_a = 48'(cd_ff); op_b = base_ff; end
         OP_WEIGHT: begin op_a = 48'(mass_ff); op_b = 48'(gravity_ff); end
         OP_W_SIN: begin op_a = w_ff; op_b = sn_w; end
         OP_W_COS: begin op_a = w_ff; op_b = cs_w; end
         OP_MV: begin op_a = 48'(mass_ff); op_b = 48'(speed_ff); end
         OP_DX: begin op_a = 48'(speed_ff); op_b = cs_w; end
         OP_DH: begin op_a = 48'(speed_ff); op_b = sn_w; end
         OP_DIV_V: begin
            is_div = 1'b1;
            nsum = -49'(drag_ff) - 49'(t1_ff);
            op_b = 48'(mass_ff);
         end
         OP_DIV_G: begin
            is_div = 1'b1;
            nsum = 49'(lift_ff) - 49'(t2_ff);
            op_b = mv_ff;
         end
         OP_DV_DT: begin op_a = dv_ff; op_b = 48'(time_step_ff); end
         OP_DG_DT: begin op_a = dg_ff; op_b = 48'(time_step_ff); end
         OP_DX_DT: begin op_a = dx_ff; op_b = 48'(time_step_ff); end
         OP_DH_DT: begin op_a = dh_ff; op_b = 48'(time_step_ff); end
         default: begin op_a = '0; op_b = '0; end
      endcase
      // clip of the divide numerator
      nsat = (nsum > MAXM49) || (nsum < -MAXM49);
      if (nsum > MAXM49) begin
         nclip = $signed(gpe_pkg::MAXM);
      end else if (nsum < -MAXM49) begin
         nclip = -$signed(gpe_pkg::MAXM);
      end else begin
         nclip = nsum[47:0];
      end
      if (is_div) begin
         op_a = nclip;
      end
   end

   // unit requests and answer
   always_comb begin
      mul_req.start = (state_ff == ST_ISSUE) && !is_div;
      mul_req.a = op_a;
      mul_req.b = op_b;
      div_req.start = (state_ff == ST_ISSUE) && is_div;
      div_req.a = op_a;
      div_req.b = op_b;
      unit_done = is_div ? div_rsp.done : mul_rsp.done;
      unit_ovf = is_div ? div_rsp.ovf : mul_rsp.ovf;
      unit_value = is_div ? div_rsp.value : mul_rsp.value;
   end

   // state update sums
   always_comb begin
      sp_sum = 49'(speed_ff) + 49'(dv_ff);
      an_sum = 49'(angle_ff) + 49'(dg_ff);
      po_sum = 49'(pos_ff) + 49'(dx_ff);
      he_sum = 49'(height_ff) + 49'(dh_ff);
      t_sum = {1'b0, time_ff} + {1'b0, time_step_ff};
      load_stop = !((end_time_ff != '0) && (req_data.initial_height > 48'sd0));
      step_stop = !((time_ff < end_time_ff) && (height_ff > 48'sd0));
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      speed_in = speed_ff;
      angle_in = angle_ff;
      pos_in = pos_ff;
      height_in = height_ff;
      time_in = time_ff;
      stop_in = stop_ff;
      ovf_in = ovf_ff;
      rmag_in = rmag_ff;
      zneg_in = zneg_ff;
      k_in = k_ff;
      z_in = z_ff;
      x_in = x_ff;
      y_in = y_ff;
      flip_in = flip_ff;
      iter_in = iter_ff;
      op_in = op_ff;
      base_in = base_ff;
      lift_in = lift_ff;
      drag_in = drag_ff;
      w_in = w_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      mv_in = mv_ff;
      dx_in = dx_ff;
      dh_in = dh_ff;
      dv_in = dv_ff;
      dg_in = dg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ovf_in = 1'b0;
               if (!req_data.action) begin
                  speed_in = req_data.initial_speed;
                  angle_in = req_data.initial_angle;
                  pos_in = req_data.initial_position;
                  height_in = req_data.initial_height;
                  time_in = '0;
                  stop_in = load_stop;
                  state_in = ST_DONE;
               end else if (step_stop) begin
                  stop_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  stop_in = 1'b0;
                  rmag_in = ang46[45] ? 46'(-ang46) : 46'(ang46);
                  zneg_in = ang46[45];
                  k_in = 4'd13;
                  state_in = ST_REDUCE;
               end
            end
         end
         // remainder modulo two pi, one multiple per cycle
         ST_REDUCE: begin
            if ({1'b0, rmag_ff} >= twopi_k) begin
               rmag_in = rmag_ff - twopi_k[45:0];
            end
            k_in = k_ff - 4'd1;
            if (k_ff == 4'd0) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (zs > gpe_pkg::PI_Q30) begin
               z_in = zs - gpe_pkg::TWOPI_Q30;
            end else if (zs < -gpe_pkg::PI_Q30) begin
               z_in = zs + gpe_pkg::TWOPI_Q30;
            end else begin
               z_in = zs;
            end
            state_in = ST_FLIP;
         end
         // fold into the right half plane
         ST_FLIP: begin
            flip_in = 1'b0;
            if (z_ff > gpe_pkg::HALFPI_Q30) begin
               z_in = gpe_pkg::PI_Q30 - z_ff;
               flip_in = 1'b1;
            end else if (z_ff < -gpe_pkg::HALFPI_Q30) begin
               z_in = -gpe_pkg::PI_Q30 - z_ff;
               flip_in = 1'b1;
            end
            x_in = gpe_pkg::GAIN_Q30;
            y_in = '0;
            iter_in = '0;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (z_ff >= 35'sd0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_z;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_z;
            end
            iter_in = iter_ff + 6'd1;
            if (iter_ff == ITER_LAST) begin
               op_in = OP_BASE_RHO;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (is_div && nsat) begin
               ovf_in = 1'b1;
            end
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               ovf_in = ovf_ff | unit_ovf;
               case (op_ff) inside
                  OP_BASE_RHO, OP_BASE_V1, OP_BASE_V2, OP_BASE_S: base_in = unit_value;
                  OP_LIFT: lift_in = unit_value;
                  OP_DRAG: drag_in = unit_value;
                  OP_WEIGHT: w_in = unit_value;
                  OP_W_SIN: t1_in = unit_value;
                  OP_W_COS: t2_in = unit_value;
                  OP_MV: mv_in = unit_value;
                  OP_DX, OP_DX_DT: dx_in = unit_value;
                  OP_DH, OP_DH_DT: dh_in = unit_value;
                  OP_DIV_V, OP_DV_DT: dv_in = unit_value;
                  OP_DIV_G, OP_DG_DT: dg_in = unit_value;
                  default: base_in = base_ff;
               endcase
               if (op_ff == OP_DH_DT) begin
                  state_in = ST_UPDATE;
               end else begin
                  op_in = op_ff + 5'd1;
                  state_in = ST_ISSUE;
               end
            end
         end
         // saturating state update
         ST_UPDATE: begin
            ovf_in = ovf_ff;
            if (sp_sum > MAX32) begin
               speed_in = 32'sh7FFF_FFFF;
               ovf_in = 1'b1;
            end else if (sp_sum < MIN32) begin
               speed_in = 32'sh8000_0000;
               ovf_in = 1'b1;
            end else begin
               speed_in = sp_sum[31:0];
            end
            if (an_sum > MAX32) begin
               angle_in = 32'sh7FFF_FFFF;
               ovf_in = 1'b1;
            end else if (an_sum < MIN32) begin
               angle_in = 32'sh8000_0000;
               ovf_in = 1'b1;
            end else begin
               angle_in = an_sum[31:0];
            end
            if (po_sum[48] != po_sum[47]) begin
               pos_in = po_sum[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
               ovf_in = 1'b1;
            end else begin
               pos_in = po_sum[47:0];
            end
            if (he_sum[48] != he_sum[47]) begin
               height_in = he_sum[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
               ovf_in = 1'b1;
            end else begin
               height_in = he_sum[47:0];
            end
            if (t_sum[32]) begin
               time_in = 32'hFFFF_FFFF;
               ovf_in = 1'b1;
            end else begin
               time_in = t_sum[31:0];
            end
            state_in = ST_DONE;
         end
         // hand the result to the output register
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.time_now = time_ff;
               rsp_data_in.speed_now = speed_ff;
               rsp_data_in.angle_now = angle_ff;
               rsp_data_in.position_now = pos_ff;
               rsp_data_in.height_now = height_ff;
               rsp_data_in.stopped = stop_ff;
               rsp_data_in.overflow = ovf_ff && !stop_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= 32'd655;
         end_time_ff <= 32'd6553600;
         mass_ff <= 32'd65536;
         gravity_ff <= 32'd642908;
         rho_ff <= 32'd80282;
         area_ff <= 32'd65536;
         cl_ff <= '0;
         cd_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            gpe_pkg::REG_TIME_STEP: time_step_ff <= csr_data;
            gpe_pkg::REG_END_TIME: end_time_ff <= csr_data;
            gpe_pkg::REG_MASS: mass_ff <= csr_data;
            gpe_pkg::REG_GRAVITY: gravity_ff <= csr_data;
            gpe_pkg::REG_AIR_DENSITY: rho_ff <= csr_data;
            gpe_pkg::REG_WING_AREA: area_ff <= csr_data;
            gpe_pkg::REG_LIFT_COEF: cl_ff <= csr_data;
            gpe_pkg::REG_DRAG_COEF: cd_ff <= csr_data[30:0];
            default: cd_ff <= cd_ff;
         endcase
      end
   end

   // control and integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         speed_ff <= '0;
         angle_ff <= '0;
         pos_ff <= '0;
         height_ff <= '0;
         time_ff <= '0;
         stop_ff <= 1'b0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         speed_ff <= speed_in;
         angle_ff <= angle_in;
         pos_ff <= pos_in;
         height_ff <= height_in;
         time_ff <= time_in;
         stop_ff <= stop_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rmag_ff <= rmag_in;
      zneg_ff <= zneg_in;
      k_ff <= k_in;
      z_ff <= z_in;
      x_ff <= x_in;
      y_ff <= y_in;
      flip_ff <= flip_in;
      iter_ff <= iter_in;
      op_ff <= op_in;
      base_ff <= base_in;
      lift_ff <= lift_in;
      drag_ff <= drag_in;
      w_ff <= w_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      mv_ff <= mv_in;
      dx_ff <= dx_in;
      dh_ff <= dh_in;
      dv_ff <= dv_in;
      dg_ff <= dg_in;
   end

   // the two units are never started together
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_req.start && div_req.start))
      else $error("multiplier and divider started together");

   // an accepted item closes the input until its result is handed to the output register
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after a transfer");

   // a new result appears only from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid) || !$past(rsp_stall)) && rsp_valid |-> $past(state_ff) == ST_DONE)
      else $error("result written outside the done state");

   // unit answers arrive only while the sequencer waits
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      (mul_rsp.done || div_rsp.done) |-> state_ff == ST_WAIT)
      else $error("unit answer outside the wait state");

endmodule

`default_nettype wire

// ===== sim/gpe_tb_pkg.sv =====
// item action codes shared by the glide path testbench files
`timescale 1ns / 1ps

package gpe_tb_pkg;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_STEP = 1'b1
   } action_type;

endpackage

// ===== sim/glide_path_checker.sv =====
// channel monitor, glide path predictor and result comparison
`timescale 1ns / 1ps

module glide_path_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire gpe_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire gpe_pkg::rsp_type rsp_data,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_data,
   output int                    errors,
   output int                    pending
);

   localparam longint LIM = 64'sh7FFF_FFFF_FFFF;
   localparam longint unsigned LOW32 = 64'hFFFF_FFFF;
   localparam longint PI_L = 64'sd3373259426;
   localparam longint HALFPI_L = 64'sd1686629713;
   localparam longint TWOPI_L = 64'sd6746518852;
   localparam longint GAIN_L = 64'sd652032874;
   localparam longint HALF_L = 64'sd32768;

   // arctangent of 2^-i in q2.30
   localparam longint ATAN_TAB [0:31] = '{
      843314856, 497837829, 263043836, 133525158, 67021687, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
      15, 7, 3, 1, 0, 0};

   // modeled configuration and flight state
   longint unsigned dt_q, end_q, mass_q, grav_q, rho_q, area_q, cd_q;
   longint cl_q;
   longint speed_q, angle_q, pos_q, height_q;
   longint unsigned time_q;
   bit sat_seen;
   gpe_pkg::rsp_type flight_results [$];

   function automatic longint limit_to(longint v, longint lo, longint hi);
      if (v > hi) begin
         sat_seen = 1;
         return hi;
      end
      if (v < lo) begin
         sat_seen = 1;
         return lo;
      end
      return v;
   endfunction

   function automatic longint unsigned abs_of(longint v);
      return v < 0 ? 64'd0 - longint'(v) : longint'(v);
   endfunction

   // truncating, saturating q32.16 multiply
   function automatic longint fx_mul(longint a, longint b);
      bit neg;
      longint unsigned ua, ub, ah, al, bh, bl, mid, r;
      neg = (a < 0) != (b < 0);
      ua = abs_of(a);
      ub = abs_of(b);
      ah = ua >> 32;
      al = ua & LOW32;
      bh = ub >> 32;
      bl = ub & LOW32;
      if (ah != 0 && bh != 0) begin
         sat_seen = 1;
         r = LIM;
      end else begin
         mid = ah * bl + al * bh;
         if (mid >= 64'h8000_0000) begin
            sat_seen = 1;
            r = LIM;
         end else begin
            r = (mid << 16) + ((al * bl) >> 16);
            if (r > LIM) begin
               sat_seen = 1;
               r = LIM;
            end
         end
      end
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // truncating, saturating q32.16 divide
   function automatic longint fx_div(longint n, longint d);
      longint unsigned un, ud, q;
      un = abs_of(n);
      ud = abs_of(d);
      if (ud == 0) begin
         sat_seen = 1;
         return n < 0 ? -LIM : LIM;
      end
      q = (un << 16) / ud;
      if (q > LIM) begin
         sat_seen = 1;
         q = LIM;
      end
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
   endfunction

   // sine and cosine of a q16.16 angle by rotation cordic
   function automatic void path_trig(input longint ang, output longint sn,
                                     output longint cs);
      longint z, x, y, nx;
      bit flip;
      z = (ang * 16384) % TWOPI_L;
      x = GAIN_L;
      y = 0;
      flip = 0;
      if (z > PI_L) z -= TWOPI_L;
      if (z < -PI_L) z += TWOPI_L;
      if (z > HALFPI_L) begin
         z = PI_L - z;
         flip = 1;
      end else if (z < -HALFPI_L) begin
         z = -PI_L - z;
         flip = 1;
      end
      for (int i = 0; i < gpe_pkg::CORDIC_ITERATIONS && i < 32; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_TAB[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_TAB[i];
         end
         x = nx;
      end
      sn = y >>> 14;
      cs = (flip ? -x : x) >>> 14;
   endfunction

   // advance the modeled glide by one item and form its result
   function automatic gpe_pkg::rsp_type glide_update(gpe_pkg::req_type it);
      gpe_pkg::rsp_type r;
      bit halted;
      longint v, sn, cs, base, lift, drag, w, m, dv, dg, dx, dh, dt;
      longint unsigned t;
      sat_seen = 0;
      if (it.action == gpe_tb_pkg::ACT_LOAD) begin
         speed_q = longint'($signed(it.initial_speed));
         angle_q = longint'($signed(it.initial_angle));
         pos_q = longint'($signed(it.initial_position));
         height_q = longint'($signed(it.initial_height));
         time_q = 0;
         halted = !(time_q < end_q && height_q > 0);
      end else if (!(time_q < end_q && height_q > 0)) begin
         halted = 1;
      end else begin
         v = speed_q;
         m = longint'(mass_q);
         dt = longint'(dt_q);
         path_trig(angle_q, sn, cs);
         base = fx_mul(HALF_L, longint'(rho_q));
         base = fx_mul(base, v);
         base = fx_mul(base, v);
         base = fx_mul(base, longint'(area_q));
         lift = fx_mul(cl_q, base);
         drag = fx_mul(longint'(cd_q), base);
         w = fx_mul(m, longint'(grav_q));
         dv = fx_div(limit_to(-drag - fx_mul(w, sn), -LIM, LIM), m);
         dg = fx_div(limit_to(lift - fx_mul(w, cs), -LIM, LIM), fx_mul(m, v));
         dx = fx_mul(v, cs);
         dh = fx_mul(v, sn);
         speed_q = limit_to(v + fx_mul(dv, dt), -64'sd2147483648, 64'sd2147483647);
         angle_q = limit_to(angle_q + fx_mul(dg, dt), -64'sd2147483648, 64'sd2147483647);
         pos_q = limit_to(pos_q + fx_mul(dx, dt), -LIM - 1, LIM);
         height_q = limit_to(height_q + fx_mul(dh, dt), -LIM - 1, LIM);
         t = time_q + dt_q;
         if (t > LOW32) begin
            sat_seen = 1;
            t = LOW32;
         end
         time_q = t;
         halted = 0;
      end
      r.time_now = time_q[31:0];
      r.speed_now = speed_q[31:0];
      r.angle_now = angle_q[31:0];
      r.position_now = pos_q[47:0];
      r.height_now = height_q[47:0];
      r.stopped = halted;
      r.overflow = (it.action == gpe_tb_pkg::ACT_STEP) && sat_seen;
      return r;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // watch transfers on every port
   always @(posedge clock) begin
      gpe_pkg::rsp_type want;
      if (reset) begin
         dt_q = 655;
         end_q = 6553600;
         mass_q = 65536;
         grav_q = 642908;
         rho_q = 80282;
         area_q = 65536;
         cl_q = 0;
         cd_q = 0;
         speed_q = 0;
         angle_q = 0;
         pos_q = 0;
         height_q = 0;
         time_q = 0;
         flight_results.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               gpe_pkg::REG_TIME_STEP: dt_q = csr_data;
               gpe_pkg::REG_END_TIME: end_q = csr_data;
               gpe_pkg::REG_MASS: mass_q = csr_data;
               gpe_pkg::REG_GRAVITY: grav_q = csr_data;
               gpe_pkg::REG_AIR_DENSITY: rho_q = csr_data;
               gpe_pkg::REG_WING_AREA: area_q = csr_data;
               gpe_pkg::REG_LIFT_COEF: cl_q = longint'($signed(csr_data));
               gpe_pkg::REG_DRAG_COEF: cd_q = csr_data[30:0];
               default: ;
            endcase
         end
         // input transfer
         if (req_valid && !req_stall)
            flight_results.push_back(glide_update(req_data));
         // result transfer
         if (rsp_valid && !rsp_stall) begin
            if (flight_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result expected none actual %h", $time, rsp_data);
            end else begin
               want = flight_results.pop_front();
               check_field("time_now", want.time_now, rsp_data.time_now);
               check_field("speed_now", want.speed_now, rsp_data.speed_now);
               check_field("angle_now", want.angle_now, rsp_data.angle_now);
               check_field("position_now", want.position_now, rsp_data.position_now);
               check_field("height_now", want.height_now, rsp_data.height_now);
               check_field("stopped", want.stopped, rsp_data.stopped);
               check_field("overflow", want.overflow, rsp_data.overflow);
            end
         end
      end
      pending <= flight_results.size();
   end

   initial errors = 0;

endmodule

// ===== sim/tb_glide_path_euler_step.sv =====
// top of the glide path integrator testbench: clock, stimulus and verdict
`timescale 1ns / 1ps

module tb_glide_path_euler_step;

   localparam int QUIET_LIMIT = 6000;
   localparam int PHASE_ITEMS = 330;
   localparam int LONG_HOLD = 900;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   gpe_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   gpe_pkg::rsp_type rsp_data;
   logic csr_we = 0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   int errors, pending;
   bit calm = 0;
   bit hold_go = 0;
   bit hold_done = 0;
   int hold_left = 0;
   int stall_left = 0;
   int quiet = 0;

   always #6 clock = ~clock;

   glide_path_euler_step uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   glide_path_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending)
   );

   // result side back-pressure, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // offer one item and wait for its transfer, then maybe idle
   task automatic send_item(gpe_pkg::req_type it);
      int gap;
      req_data <= it;
      req_valid <= 1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_load(logic [31:0] spd, logic [31:0] ang, logic [47:0] pos,
                            logic [47:0] hgt);
      gpe_pkg::req_type it;
      it.action = gpe_tb_pkg::ACT_LOAD;
      it.initial_speed = spd;
      it.initial_angle = ang;
      it.initial_position = pos;
      it.initial_height = hgt;
      send_item(it);
   endtask

   // a step carries random unused fields
   task automatic send_step();
      gpe_pkg::req_type it;
      it = {1'b0, $urandom, $urandom, 16'($urandom), $urandom, 16'($urandom), $urandom};
      it.action = gpe_tb_pkg::ACT_STEP;
      send_item(it);
   endtask

   // wait until every expected result has come back
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_all(logic [31:0] dt, logic [31:0] tend, logic [31:0] m,
                            logic [31:0] g, logic [31:0] rho, logic [31:0] area,
                            logic [31:0] cl, logic [31:0] cd);
      logic [31:0] vals [8];
      vals = '{dt, tend, m, g, rho, area, cl, cd};
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1;
         csr_index <= i[2:0];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_we <= 0;
      @(posedge clock);
   endtask

   // one phase of random flights
   task automatic fly_random(int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 99) < 85) begin
            send_load($urandom_range(0, 99) < 80 ? $urandom_range(0, 32'h00C8_0000)
                                                 : $urandom,
                      $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000,
                      {$urandom, $urandom},
                      $urandom_range(0, 99) < 85 ? 48'($urandom_range(1, 32'h2710_0000))
                                                 : 48'({$urandom, $urandom}));
            n = $urandom_range(1, 12);
            sent += 1 + n;
            repeat (n) send_step();
         end else begin
            if ($urandom_range(0, 1)) send_step();
            else send_load($urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset state, plain glide, zero speed, extremes, stop cases
      send_step();
      send_load(32'h000A_0000, 32'h0, 48'h0, 48'h0064_0000);
      repeat (3) send_step();
      send_load(32'h0, 32'h0000_4000, 48'h0, 48'h0064_0000);
      send_step();
      send_load(32'h7FFF_FFFF, 32'h8000_0000, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
      repeat (2) send_step();
      send_load(32'h8000_0000, 32'h7FFF_FFFF, 48'h8000_0000_0000, 48'h1);
      send_step();
      send_load(32'h0014_0000, 32'h0, 48'h0, 48'hFFFF_FFFF_0000);
      send_step();
      send_load(32'h0014_0000, 32'h0007_0000, 48'h0, 48'h03E8_0000);
      send_step();
      send_load(32'h0014_0000, 32'hFFF6_0000, 48'h0, 48'h03E8_0000);
      send_step();
      drain();

      // zero time step, lift and drag active
      write_all(32'h0, 32'h0064_0000, 32'h0001_0000, 32'd642908, 32'd80282,
                32'h0001_0000, 32'h0000_8000, 32'h0000_1000);
      send_load(32'h0014_0000, 32'h0, 48'h0, 48'h0064_0000);
      repeat (3) send_step();
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_all($urandom_range(1, 6554), 32'hFFFF_FFFF,
                         $urandom_range(32'h0001_0000, 32'h07D0_0000), 32'd642908,
                         $urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0064_0000),
                         $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                         $urandom_range(0, 32'h0001_0000));
            1: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
            2: write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
            3: write_all(32'h1, $urandom_range(0, 32'h0000_0100), 32'h1, 32'h0, 32'h0,
                         32'h0, 32'h8000_0000, 32'h0);
            default: begin
               calm = 1;
               write_all($urandom_range(1, 32'h0001_0000), $urandom, $urandom, $urandom,
                         $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0010_0000),
                         $urandom, $urandom);
            end
         endcase
         if (ph == 1) hold_go <= 1;
         fly_random(PHASE_ITEMS);
         drain();
      end

      // end time zero: everything stops at once
      write_all(32'd655, 32'h0, 32'h0001_0000, 32'd642908, 32'd80282, 32'h0001_0000,
                32'h0, 32'h0);
      send_load(32'h0014_0000, 32'h0, 48'h0, 48'h0064_0000);
      send_step();
      drain();

      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
